FILE: rtl/bth_pkg.sv
package bth_pkg;

   localparam int MEM_GRANULES      = 4096;
   localparam int GRANULE_BYTES     = 16;
   localparam int SPLIT_SLACK_BYTES = 64;

   localparam int IDX_W      = $clog2(MEM_GRANULES + 1);
   localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
   localparam int HALF_GRAN  = GRANULE_BYTES / 2;
   // a split needs sz*GB >= g*GB + GB + slack, i.e. sz >= g + SPLIT_GRANULES
   localparam int SPLIT_GRANULES = (GRANULE_BYTES + SPLIT_SLACK_BYTES + GRANULE_BYTES - 1)
                                   / GRANULE_BYTES;
   localparam int CFG_W      = 13;
   localparam int REQ_W      = 16;
   localparam int STATUS_W   = 3;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CFG_W-1:0]    cfg_type;
   typedef logic [REQ_W-1:0]    req_bytes_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam idx_type NONE_BLOCK = idx_type'(MEM_GRANULES);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam status_type ST_ALLOC_OK  = 3'd0;
   localparam status_type ST_ZERO_SIZE = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_FREED     = 3'd3;
   localparam status_type ST_EMPTIED   = 3'd4;
   localparam status_type ST_NOT_OWNED = 3'd5;

   typedef struct packed {
      idx_type size;
      logic    used;
      idx_type prev_real;
      idx_type prev_free;
      idx_type next_free;
   } hdr_type;

   typedef struct packed {
      logic size;
      logic used;
      logic prev_real;
      logic prev_free;
      logic next_free;
   } hdr_mask_type;

   function automatic idx_type clamp_idx(input logic [IDX_W:0] x);
      return (x >= {1'b0, NONE_BLOCK}) ? NONE_BLOCK : x[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/bth_req_if.sv
interface bth_req_if;
   logic                   valid;
   logic                   ready;
   logic                   action;
   bth_pkg::req_bytes_type request_bytes;
   bth_pkg::req_bytes_type object_offset;

   modport source (output valid, action, request_bytes, object_offset, input ready);
   modport sink   (input valid, action, request_bytes, object_offset, output ready);
endinterface

FILE: rtl/bth_rsp_if.sv
interface bth_rsp_if;
   logic                valid;
   logic                ready;
   bth_pkg::status_type status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

FILE: rtl/boundary_tag_heap_allocator.sv
// Channel   Dir  Handshake     Beat payload
// req_ch    in   valid/ready   action, request_bytes, object_offset
// rsp_ch    out  valid/ready   status
// csr_*     in   csr_wr_en     csr_wr_data = heap_granules
//
// One beat in flight at a time. Headers live in one 4097-entry memory (one
// read, one field-masked write per cycle, read data registered).
// Alloc: a zero size goes straight to the result; otherwise the break grows, or
// the free list is walked block by block to a block that is split or taken whole
// (then unlinked). Free: checks ownership, merges neighbours, may lower the break.
// Synchronous reset clears break/first/last/rover/full; no memory sweep.
// A pending result does not block acceptance; the next finish waits on it.
module boundary_tag_heap_allocator (
   input  logic             clock,
   input  logic             reset,
   bth_req_if.sink          req_ch,
   bth_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  bth_pkg::cfg_type csr_wr_data
);
   import bth_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_GROW, S_WK_EV, S_SP_NB, S_SP_NX, S_TK_USED,
      S_PF_RD, S_PF_EV, S_PF_W2,
      S_FR_CHK, S_FL_RD, S_FL_EV, S_FL_FIN,
      S_FI_PVR, S_FI_PVE, S_FI_PVN, S_IN_RD, S_IN_EV, S_IN_W2, S_IN_W3,
      S_NX_RD, S_NX_EV, S_NX_B, S_NX_R2, S_NX_E2,
      S_FIN_FREE, S_RESP
   } state_type;

   // header memory: slot NONE_BLOCK is the scratch entry
   hdr_type heap_mem [0:MEM_GRANULES];

   state_type    state_ff, ret_ff;
   cfg_type      cfg_ff;
   idx_type      brk_ff, first_ff, last_ff, rover_ff;
   logic         full_ff;
   idx_type      g_ff, b_ff, t_ff, start_ff, n_ff;
   idx_type      pv_ff, nx_ff, p_ff, lp_ff, r_ff, tt_ff, sznx_ff;
   idx_type      pf_ff, pfr_ff, pfp_ff;
   logic         grow_first_ff;
   hdr_type      hb_ff;
   hdr_type      rd_ff;
   status_type   st_ff;
   logic         rsp_valid_ff;
   status_type   rsp_status_ff;

   idx_type      rd_addr;
   logic         wr_en;
   idx_type      wr_addr;
   hdr_mask_type wr_mask;
   hdr_type      wr_data;

   // request decode
   logic [REQ_W:0]       g_sum;
   idx_type              g_req;
   idx_type              eff;
   logic [IDX_W+GRAN_SHIFT-1:0] eff_bytes;
   idx_type              off_b;
   logic                 off_bad;
   logic [IDX_W:0]       grow_end;
   logic                 grow_fits;
   logic                 split_ok, take_ok;
   idx_type              walk_next;
   idx_type              nb_calc;
   logic                 pv_merge;

   always_comb begin
      g_sum     = {1'b0, req_ch.request_bytes} + (REQ_W+1)'(HALF_GRAN + GRANULE_BYTES - 1);
      g_req     = g_sum[GRAN_SHIFT +: IDX_W];
      eff       = ({1'b0, cfg_ff} < (CFG_W+1)'(MEM_GRANULES)) ? idx_type'(cfg_ff) : NONE_BLOCK;
      eff_bytes = {eff, GRAN_SHIFT'(0)};
      off_b     = idx_type'(req_ch.object_offset[REQ_W-1:GRAN_SHIFT]);
      off_bad   = (req_ch.object_offset == '0)
               || ((IDX_W+GRAN_SHIFT)'(req_ch.object_offset) >= eff_bytes)
               || (req_ch.object_offset[GRAN_SHIFT-1:0] != GRAN_SHIFT'(HALF_GRAN))
               || (off_b >= brk_ff);
      grow_end  = {1'b0, brk_ff} + {1'b0, g_ff};
      grow_fits = grow_end <= {1'b0, eff};
      split_ok  = {1'b0, rd_ff.size} >= ({1'b0, g_ff} + (IDX_W+1)'(SPLIT_GRANULES));
      take_ok   = rd_ff.size >= g_ff;
      walk_next = clamp_idx({1'b0, rd_ff.next_free});
      nb_calc   = clamp_idx({1'b0, t_ff} + {1'b0, rd_ff.size - g_ff});
      pv_merge  = (pv_ff != NONE_BLOCK) && !rd_ff.used
               && (b_ff != clamp_idx({1'b0, first_ff}));
   end

   // memory port control
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_mask = '0;
      wr_data = '0;
      case (state_ff)
         S_IDLE: begin
            rd_addr = (req_ch.action == ACT_FREE) ? off_b : clamp_idx({1'b0, rover_ff});
         end
         S_GROW: begin
            if (grow_fits) begin
               wr_en             = 1'b1;
               wr_addr           = brk_ff;
               wr_mask.size      = 1'b1;
               wr_mask.used      = 1'b1;
               wr_mask.prev_real = 1'b1;
               wr_data.size      = g_ff;
               wr_data.used      = 1'b1;
               wr_data.prev_real = grow_first_ff ? NONE_BLOCK : clamp_idx({1'b0, last_ff});
            end
         end
         S_WK_EV: begin
            rd_addr = walk_next;
            if (split_ok) begin
               wr_en        = 1'b1;
               wr_addr      = t_ff;
               wr_mask.size = 1'b1;
               wr_data.size = rd_ff.size - g_ff;
            end
         end
         S_SP_NB: begin
            wr_en             = 1'b1;
            wr_addr           = b_ff;
            wr_mask.size      = 1'b1;
            wr_mask.used      = 1'b1;
            wr_mask.prev_real = 1'b1;
            wr_data.size      = g_ff;
            wr_data.used      = 1'b1;
            wr_data.prev_real = t_ff;
         end
         S_SP_NX: begin
            wr_en             = 1'b1;
            wr_addr           = clamp_idx({1'b0, b_ff} + {1'b0, g_ff});
            wr_mask.prev_real = 1'b1;
            wr_data.prev_real = b_ff;
         end
         S_TK_USED: begin
            wr_en        = 1'b1;
            wr_addr      = t_ff;
            wr_mask.used = 1'b1;
            wr_data.used = 1'b1;
         end
         S_PF_RD: rd_addr = pf_ff;
         S_PF_EV: begin
            if (walk_next != pf_ff) begin
               wr_en             = 1'b1;
               wr_addr           = walk_next;
               wr_mask.prev_free = 1'b1;
               wr_data.prev_free = clamp_idx({1'b0, rd_ff.prev_free});
            end
         end
         S_PF_W2: begin
            wr_en             = 1'b1;
            wr_addr           = pfp_ff;
            wr_mask.next_free = 1'b1;
            wr_data.next_free = pfr_ff;
         end
         S_FR_CHK: begin
            if (rd_ff.used) begin
               wr_en        = 1'b1;
               wr_addr      = b_ff;
               wr_mask.used = 1'b1;
               wr_data.used = 1'b0;
            end
         end
         S_FL_RD:  rd_addr = p_ff;
         S_FI_PVR: rd_addr = pv_ff;
         S_FI_PVE: begin
            if (pv_merge) begin
               wr_en        = 1'b1;
               wr_addr      = pv_ff;
               wr_mask.size = 1'b1;
               wr_data.size = rd_ff.size + hb_ff.size;
            end else if (clamp_idx({1'b0, rover_ff}) == NONE_BLOCK) begin
               wr_en             = 1'b1;
               wr_addr           = b_ff;
               wr_mask.prev_free = 1'b1;
               wr_mask.next_free = 1'b1;
               wr_data.prev_free = b_ff;
               wr_data.next_free = b_ff;
            end
         end
         S_FI_PVN: begin
            wr_en             = 1'b1;
            wr_addr           = nx_ff;
            wr_mask.prev_real = 1'b1;
            wr_data.prev_real = pv_ff;
         end
         S_IN_RD: rd_addr = r_ff;
         S_IN_EV: begin
            wr_en             = 1'b1;
            wr_addr           = r_ff;
            wr_mask.next_free = 1'b1;
            wr_data.next_free = b_ff;
         end
         S_IN_W2: begin
            wr_en             = 1'b1;
            wr_addr           = tt_ff;
            wr_mask.prev_free = 1'b1;
            wr_data.prev_free = b_ff;
         end
         S_IN_W3: begin
            wr_en             = 1'b1;
            wr_addr           = b_ff;
            wr_mask.next_free = 1'b1;
            wr_mask.prev_free = 1'b1;
            wr_data.next_free = tt_ff;
            wr_data.prev_free = r_ff;
         end
         S_NX_RD: rd_addr = nx_ff;
         S_NX_EV: rd_addr = b_ff;
         S_NX_B: begin
            wr_en        = 1'b1;
            wr_addr      = b_ff;
            wr_mask.size = 1'b1;
            wr_data.size = rd_ff.size + sznx_ff;
         end
         S_NX_R2: rd_addr = nx_ff;
         S_NX_E2: begin
            if (clamp_idx({1'b0, last_ff}) != nx_ff) begin
               wr_en             = 1'b1;
               wr_addr           = clamp_idx({1'b0, nx_ff} + {1'b0, rd_ff.size});
               wr_mask.prev_real = 1'b1;
               wr_data.prev_real = b_ff;
            end
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= heap_mem[rd_addr];
      if (wr_en) begin
         if (wr_mask.size)      heap_mem[wr_addr].size      <= wr_data.size;
         if (wr_mask.used)      heap_mem[wr_addr].used      <= wr_data.used;
         if (wr_mask.prev_real) heap_mem[wr_addr].prev_real <= wr_data.prev_real;
         if (wr_mask.prev_free) heap_mem[wr_addr].prev_free <= wr_data.prev_free;
         if (wr_mask.next_free) heap_mem[wr_addr].next_free <= wr_data.next_free;
      end
   end

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         cfg_ff       <= cfg_type'(MEM_GRANULES);
         brk_ff       <= '0;
         first_ff     <= NONE_BLOCK;
         last_ff      <= NONE_BLOCK;
         rover_ff     <= NONE_BLOCK;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cfg_ff <= csr_wr_data;
         // S_RESP handles the output register itself
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_RESP) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  g_ff     <= g_req;
                  b_ff     <= off_b;
                  t_ff     <= clamp_idx({1'b0, rover_ff});
                  start_ff <= clamp_idx({1'b0, rover_ff});
                  n_ff     <= '0;
                  if (req_ch.action == ACT_ALLOC) begin
                     if (req_ch.request_bytes == '0) begin
                        st_ff    <= ST_ZERO_SIZE;
                        state_ff <= S_RESP;
                     end else if (clamp_idx({1'b0, first_ff}) == NONE_BLOCK) begin
                        grow_first_ff <= 1'b1;
                        state_ff      <= S_GROW;
                     end else if (clamp_idx({1'b0, rover_ff}) == NONE_BLOCK) begin
                        grow_first_ff <= 1'b0;
                        state_ff      <= S_GROW;
                     end else begin
                        state_ff <= S_WK_EV;
                     end
                  end else if (off_bad) begin
                     st_ff    <= ST_NOT_OWNED;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_FR_CHK;
                  end
               end
            end
            S_GROW: begin
               if (!grow_fits) begin
                  full_ff  <= 1'b1;
                  st_ff    <= ST_FULL;
               end else begin
                  brk_ff  <= grow_end[IDX_W-1:0];
                  last_ff <= brk_ff;
                  if (grow_first_ff) first_ff <= brk_ff;
                  st_ff   <= ST_ALLOC_OK;
               end
               state_ff <= S_RESP;
            end
            // one free-list block per cycle; next read already issued
            S_WK_EV: begin
               if (split_ok) begin
                  b_ff     <= nb_calc;
                  state_ff <= S_SP_NB;
               end else if (take_ok) begin
                  pf_ff    <= t_ff;
                  ret_ff   <= S_TK_USED;
                  state_ff <= S_PF_RD;
               end else if (walk_next == start_ff || n_ff == idx_type'(MEM_GRANULES)) begin
                  grow_first_ff <= 1'b0;
                  state_ff      <= S_GROW;
               end else begin
                  t_ff <= walk_next;
                  n_ff <= n_ff + idx_type'(1);
               end
            end
            S_SP_NB: begin
               if (clamp_idx({1'b0, last_ff}) == t_ff) begin
                  last_ff  <= b_ff;
                  st_ff    <= ST_ALLOC_OK;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_SP_NX;
               end
            end
            S_SP_NX, S_TK_USED: begin
               st_ff    <= ST_ALLOC_OK;
               state_ff <= S_RESP;
            end
            // unlink pf_ff from the free list
            S_PF_RD: state_ff <= S_PF_EV;
            S_PF_EV: begin
               if (walk_next == pf_ff) begin
                  rover_ff <= NONE_BLOCK;
                  state_ff <= ret_ff;
               end else begin
                  rover_ff <= walk_next;
                  pfr_ff   <= walk_next;
                  pfp_ff   <= clamp_idx({1'b0, rd_ff.prev_free});
                  state_ff <= S_PF_W2;
               end
            end
            S_PF_W2: state_ff <= ret_ff;
            S_FR_CHK: begin
               hb_ff <= rd_ff;
               if (!rd_ff.used) begin
                  st_ff    <= ST_NOT_OWNED;
                  state_ff <= S_RESP;
               end else if (b_ff == clamp_idx({1'b0, last_ff})) begin
                  if (clamp_idx({1'b0, first_ff}) == b_ff) begin
                     brk_ff   <= first_ff;
                     first_ff <= NONE_BLOCK;
                     last_ff  <= NONE_BLOCK;
                     state_ff <= S_FIN_FREE;
                  end else begin
                     p_ff     <= clamp_idx({1'b0, rd_ff.prev_real});
                     state_ff <= S_FL_RD;
                  end
               end else begin
                  nx_ff    <= clamp_idx({1'b0, b_ff} + {1'b0, rd_ff.size});
                  pv_ff    <= clamp_idx({1'b0, rd_ff.prev_real});
                  state_ff <= S_FI_PVR;
               end
            end
            S_FL_RD: state_ff <= S_FL_EV;
            S_FL_EV: begin
               if (!rd_ff.used) begin
                  lp_ff    <= clamp_idx({1'b0, rd_ff.prev_real});
                  pf_ff    <= p_ff;
                  ret_ff   <= S_FL_FIN;
                  state_ff <= S_PF_RD;
               end else begin
                  brk_ff   <= b_ff;
                  last_ff  <= p_ff;
                  state_ff <= S_FIN_FREE;
               end
            end
            S_FL_FIN: begin
               if (p_ff == clamp_idx({1'b0, first_ff})) begin
                  first_ff <= NONE_BLOCK;
                  last_ff  <= NONE_BLOCK;
               end else begin
                  last_ff <= lp_ff;
               end
               brk_ff   <= p_ff;
               state_ff <= S_FIN_FREE;
            end
            S_FI_PVR: state_ff <= S_FI_PVE;
            S_FI_PVE: begin
               if (pv_merge) begin
                  state_ff <= S_FI_PVN;
               end else if (clamp_idx({1'b0, rover_ff}) != NONE_BLOCK) begin
                  r_ff     <= clamp_idx({1'b0, rover_ff});
                  state_ff <= S_IN_RD;
               end else begin
                  rover_ff <= b_ff;
                  state_ff <= S_NX_RD;
               end
            end
            S_FI_PVN: begin
               b_ff     <= pv_ff;
               state_ff <= S_NX_RD;
            end
            S_IN_RD: state_ff <= S_IN_EV;
            S_IN_EV: begin
               tt_ff    <= walk_next;
               state_ff <= S_IN_W2;
            end
            S_IN_W2: state_ff <= S_IN_W3;
            S_IN_W3: state_ff <= S_NX_RD;
            S_NX_RD: state_ff <= S_NX_EV;
            S_NX_EV: begin
               sznx_ff  <= rd_ff.size;
               state_ff <= rd_ff.used ? S_FIN_FREE : S_NX_B;
            end
            S_NX_B:  state_ff <= S_NX_R2;
            S_NX_R2: state_ff <= S_NX_E2;
            S_NX_E2: begin
               if (clamp_idx({1'b0, last_ff}) == nx_ff) last_ff <= b_ff;
               pf_ff    <= nx_ff;
               ret_ff   <= S_FIN_FREE;
               state_ff <= S_PF_RD;
            end
            S_FIN_FREE: begin
               full_ff  <= 1'b0;
               st_ff    <= (brk_ff == '0) ? ST_EMPTIED : ST_FREED;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= st_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
